// ===== design/kmp_pkg.sv =====
package kmp_pkg;

    localparam int BYTE_W    = 8;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 2;
    localparam int LEN_W     = 5;
    localparam int PAT_BYTES = 16;
    localparam int PAT_W     = PAT_BYTES * BYTE_W;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_PAT_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAT_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PAT_LEN  = 2'd2;

    typedef logic [BYTE_W-1:0] t_byte;

    // pattern byte at a position, zero beyond the stored bytes
    function automatic t_byte pat_byte(input logic [PAT_W-1:0] pat, input logic [31:0] idx);
        t_byte b;
        b = '0;
        if (idx < 32'(PAT_BYTES)) begin
            b = pat[{idx[3:0], 3'b000} +: BYTE_W];
        end
        return b;
    endfunction

endpackage

// ===== design/kmp_text_if.sv =====
interface kmp_text_if;
    import kmp_pkg::*;

    logic  valid;
    logic  ready;
    t_byte text_byte;
    logic  text_last;

    modport source (output valid, output text_byte, output text_last, input ready);
    modport sink   (input valid, input text_byte, input text_last, output ready);
endinterface

// ===== design/kmp_result_if.sv =====
interface kmp_result_if;
    logic valid;
    logic ready;
    logic found_so_far;
    logic match_ends_here;
    logic result_last;

    modport source (output valid, output found_so_far, output match_ends_here,
                    output result_last, input ready);
    modport sink   (input valid, input found_so_far, input match_ends_here,
                    input result_last, output ready);
endinterface

// ===== design/kmp_fail_table.sv =====
module kmp_fail_table #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int DW    = 5
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);
    // border lengths, one entry per pattern position
    logic [DW-1:0] r_ent [DEPTH];

    // read data appears the cycle after its address
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_ent[i_waddr] <= i_wdata;
        end
        o_rdata <= r_ent[i_raddr];
    end
endmodule

// ===== design/kmp_substring_detector.sv =====
// channel   | dir | word                                         | handshake
// ----------+-----+----------------------------------------------+------------------
// i_text    | in  | text_byte[7:0], text_last                    | valid / ready
// o_result  | out | found_so_far, match_ends_here, result_last   | valid / ready
// i_cfg_*   | in  | i_cfg_idx[1:0], i_cfg_data[63:0]             | i_cfg_we, no wait
//
// one text word passes through these steps, f being the failure links followed
// for it (0 .. n-1): the accept, one compare, a table read and a new compare per
// link, one output load. links never outnumber advances over a text.
// the single byte comparator and the failure table, read the cycle after its
// address, set these steps.
// after reset or a register write the table is rebuilt, during which no text
// word is taken; n is the saturated pattern length.
// a finished result waits in the output register; while that register holds an
// untaken result the next word waits in its last cycle.
module kmp_substring_detector #(
    parameter int MAX_PATTERN = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    kmp_text_if.sink                       i_text,
    kmp_result_if.source                   o_result,
    input  logic                           i_cfg_we,
    input  logic [kmp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [kmp_pkg::CFG_W-1:0]      i_cfg_data
);
    import kmp_pkg::*;

    // position width holds 0..MAX_PATTERN, table address 0..MAX_PATTERN-1
    localparam int PW = $clog2(MAX_PATTERN + 1);
    localparam int AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    // sequencer states
    localparam logic [2:0] ST_BUILD = 3'd0;
    localparam logic [2:0] ST_BLINK = 3'd1;
    localparam logic [2:0] ST_IDLE  = 3'd2;
    localparam logic [2:0] ST_SCAN  = 3'd3;
    localparam logic [2:0] ST_SLINK = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0]       r_state;
    logic [CFG_W-1:0] r_pat_low;
    logic [CFG_W-1:0] r_pat_high;
    logic [LEN_W-1:0] r_len;

    // build pointers: q walks the pattern, k is the current border length
    logic [PW-1:0]    r_q;
    logic [PW-1:0]    r_k;
    logic [PW-1:0]    r_full_fall;

    // scan state
    logic [PW-1:0]    r_pos;
    logic             r_found;
    logic             r_hit;
    t_byte            r_byte;
    logic             r_last;

    // output register
    logic             r_out_valid;
    logic             r_out_found;
    logic             r_out_hit;
    logic             r_out_last;

    logic [PAT_W-1:0] w_pat;
    logic [PW-1:0]    w_n;
    logic             w_cfg_hit;
    t_byte            w_cmp_a;
    t_byte            w_cmp_b;
    logic             w_eq;
    logic [PW-1:0]    w_link_idx;
    logic [AW-1:0]    w_raddr;
    logic [PW-1:0]    w_rdata;
    logic             w_tab_we;
    logic [AW-1:0]    w_waddr;
    logic [PW-1:0]    w_wdata;
    logic [PW-1:0]    w_k_next;
    logic [PW-1:0]    w_pos_next;
    logic             w_accept;
    logic             w_out_free;
    logic             w_load_out;

    assign w_pat = {r_pat_high, r_pat_low};

    // saturate the length to the table depth
    always_comb begin
        if (32'(r_len) > MAX_PATTERN) begin
            w_n = PW'(MAX_PATTERN);
        end else begin
            w_n = PW'(r_len);
        end
    end

    assign w_cfg_hit = i_cfg_we && (i_cfg_idx == REG_PAT_LOW || i_cfg_idx == REG_PAT_HIGH
                                    || i_cfg_idx == REG_PAT_LEN);

    // shared byte comparator: p[q] vs p[k] while building, text vs p[pos] while scanning
    always_comb begin
        if (r_state == ST_SCAN) begin
            w_cmp_a    = r_byte;
            w_cmp_b    = pat_byte(w_pat, 32'(r_pos));
            w_link_idx = r_pos;
        end else begin
            w_cmp_a    = pat_byte(w_pat, 32'(r_q));
            w_cmp_b    = pat_byte(w_pat, 32'(r_k));
            w_link_idx = r_k;
        end
    end

    assign w_eq       = (w_cmp_a == w_cmp_b);
    // link address goes out in the compare cycle, its entry is back the next cycle
    assign w_raddr    = AW'(w_link_idx - PW'(1));
    assign w_k_next   = r_k + PW'(w_eq);
    assign w_pos_next = r_pos + PW'(w_eq);

    // table write: entry 0 first, then one entry per advancing build step
    always_comb begin
        w_tab_we = 1'b0;
        w_waddr  = AW'(r_q);
        w_wdata  = w_k_next;
        if (r_state == ST_BUILD && r_q == '0) begin
            w_tab_we = 1'b1;
            w_wdata  = '0;
        end else if (r_state == ST_BUILD && r_q < w_n && !(r_k != '0 && !w_eq)) begin
            w_tab_we = 1'b1;
        end
    end

    kmp_fail_table #(
        .DEPTH (MAX_PATTERN),
        .AW    (AW),
        .DW    (PW)
    ) u_fail_table (
        .i_clk   (i_clk),
        .i_we    (w_tab_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign i_text.ready = (r_state == ST_IDLE);
    assign w_accept     = i_text.valid && i_text.ready;
    assign w_out_free   = !r_out_valid || o_result.ready;
    assign w_load_out   = (r_state == ST_DONE) && w_out_free;

    assign o_result.valid           = r_out_valid;
    assign o_result.found_so_far    = r_out_found;
    assign o_result.match_ends_here = r_out_hit;
    assign o_result.result_last     = r_out_last;

    // output register: loaded from the last cycle of a word, freed when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
            r_out_found <= r_found;
            r_out_hit   <= r_hit;
            r_out_last  <= r_last;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_BUILD;
            r_pat_low   <= '0;
            r_pat_high  <= '0;
            r_len       <= '0;
            r_q         <= '0;
            r_k         <= '0;
            r_full_fall <= '0;
            r_pos       <= '0;
            r_found     <= 1'b0;
            r_hit       <= 1'b0;
        end else if (w_cfg_hit) begin
            // register write restarts the text and rebuilds the table
            unique case (i_cfg_idx)
                REG_PAT_LOW:  r_pat_low  <= i_cfg_data;
                REG_PAT_HIGH: r_pat_high <= i_cfg_data;
                REG_PAT_LEN:  r_len      <= i_cfg_data[LEN_W-1:0];
                default:      r_len      <= r_len;
            endcase
            r_state <= ST_BUILD;
            r_q     <= '0;
            r_pos   <= '0;
            r_found <= 1'b0;
        end else begin
            unique case (r_state)
                ST_BUILD: begin
                    if (r_q == '0) begin
                        r_q         <= PW'(1);
                        r_k         <= '0;
                        r_full_fall <= '0;
                    end else if (r_q >= w_n) begin
                        r_state <= ST_IDLE;
                    end else if (r_k != '0 && !w_eq) begin
                        // follow a border link once the entry is read
                        r_state <= ST_BLINK;
                    end else begin
                        r_k         <= w_k_next;
                        r_full_fall <= w_k_next;
                        r_q         <= r_q + PW'(1);
                    end
                end
                ST_BLINK: begin
                    r_k     <= w_rdata;
                    r_state <= ST_BUILD;
                end
                ST_IDLE: begin
                    if (w_accept) begin
                        r_byte  <= i_text.text_byte;
                        r_last  <= i_text.text_last;
                        r_hit   <= 1'b0;
                        r_state <= ST_SCAN;
                        if (r_pos >= w_n) begin
                            r_pos <= '0;
                        end
                    end
                end
                ST_SCAN: begin
                    if (w_n == '0) begin
                        // empty pattern is always found
                        r_found <= 1'b1;
                        r_state <= ST_DONE;
                    end else if (r_pos != '0 && !w_eq) begin
                        r_state <= ST_SLINK;
                    end else if (w_pos_next >= w_n) begin
                        r_hit   <= 1'b1;
                        r_found <= 1'b1;
                        r_pos   <= r_full_fall;
                        r_state <= ST_DONE;
                    end else begin
                        r_pos   <= w_pos_next;
                        r_state <= ST_DONE;
                    end
                end
                ST_SLINK: begin
                    r_pos   <= w_rdata;
                    r_state <= ST_SCAN;
                end
                ST_DONE: begin
                    if (w_out_free) begin
                        r_state <= ST_IDLE;
                        if (r_last) begin
                            r_pos   <= '0;
                            r_found <= 1'b0;
                        end
                    end
                end
                default: begin
                    r_state <= ST_BUILD;
                end
            endcase
        end
    end

    // a reported match always comes with the found flag
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> (!o_result.match_ends_here || o_result.found_so_far))
        else $error("match reported without found flag");

    // no text word is taken while the table is being built
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_BUILD) |-> !i_text.ready)
        else $error("text accepted during table build");

    // between words the position is a live prefix of the pattern
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && w_n != '0) |-> (r_pos < w_n))
        else $error("match position out of range");

    // the border stays shorter than the prefix it belongs to
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_BUILD && r_q != '0) |-> (r_k < r_q))
        else $error("border not shorter than prefix");

    // one word at a time: ready drops right after an accept
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !i_text.ready)
        else $error("second word taken while one is in work");
endmodule
